/* rtl/awsm_pkg.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// awsm_pkg
// Shared types and constants of the all-words substring matcher: register
// map, query word packing and the configuration bundle.
// -----------------------------------------------------------------------------
package awsm_pkg;

   // query word registers: four words of up to eight bytes each
   localparam int REG_WORDS = 4;
   localparam int REG_BYTES = 8;
   localparam int QWORD_W   = 8 * REG_BYTES;
   localparam int LEN_W     = 4;
   localparam int COUNT_W   = 3;

   // register port
   localparam int DATA_W = 64;
   localparam int ADDR_W = 6;
   localparam int IDX_W  = 3;

   // register indexes (byte address 8 * index)
   localparam logic [IDX_W-1:0] REG_QUERY_0 = 3'd0;
   localparam logic [IDX_W-1:0] REG_QUERY_1 = 3'd1;
   localparam logic [IDX_W-1:0] REG_QUERY_2 = 3'd2;
   localparam logic [IDX_W-1:0] REG_QUERY_3 = 3'd3;
   localparam logic [IDX_W-1:0] REG_LENGTHS = 3'd4;
   localparam logic [IDX_W-1:0] REG_COUNT   = 3'd5;
   localparam logic [IDX_W-1:0] REG_FOLD    = 3'd6;

   // ASCII upper-case range and case offset
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   // parameter defaults
   localparam int DEF_MAX_WORDS  = 4;
   localparam int DEF_WORD_BYTES = 8;

   typedef struct packed {
      logic [REG_WORDS-1:0][QWORD_W-1:0] words;
      logic [REG_WORDS*LEN_W-1:0]        lengths;
      logic [COUNT_W-1:0]                count;
      logic                              fold;
   } cfg_type;

endpackage

/* rtl/all_words_substring_matcher.sv */
`timescale 1ns / 1ps
// A line's last byte waits in the input register while the result slot is full
// and untaken; it then advances and its result is held in the result register.
// Throughput: one text byte per cycle except during that wait; the window and the
// per-word comparators sit between the request register and the result register.
// Reset: synchronous, active high; clears configuration, line state and
// both valid flags. No clearing pass; the block is ready the cycle after reset.
// -----------------------------------------------------------------------------
// all_words_substring_matcher
// Reports on the last byte of each line whether all query words occur in it.
// -----------------------------------------------------------------------------
module all_words_substring_matcher #(
   parameter int MAX_WORDS  = awsm_pkg::DEF_MAX_WORDS,
   parameter int WORD_BYTES = awsm_pkg::DEF_WORD_BYTES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_text_byte,
   input  logic                          req_line_end,
   input  logic [7:0]                    req_line_tag,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [7:0]                    rsp_tag_out,
   output logic                          rsp_all_found,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [awsm_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [awsm_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [awsm_pkg::DATA_W-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import awsm_pkg::*;

   cfg_type    cfg;
   logic       s1_valid_ff;
   logic [7:0] s1_byte_ff;
   logic       s1_last_ff;
   logic [7:0] s1_tag_ff;
   logic       out_free;
   logic       s1_adv;
   logic       req_accept;
   logic       found;
   logic       rsp_valid_ff;
   logic [7:0] rsp_tag_ff;
   logic       rsp_found_ff;

   awsm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   awsm_match #(
      .MAX_WORDS  (MAX_WORDS),
      .WORD_BYTES (WORD_BYTES)
   ) u_match (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .advance   (s1_adv),
      .text_byte (s1_byte_ff),
      .line_end  (s1_last_ff),
      .all_found (found)
   );

   // a byte advances unless it ends a line and the result slot is full and not being taken
   assign out_free   = ~rsp_valid_ff | rsp_ready;
   assign s1_adv     = s1_valid_ff & (~s1_last_ff | out_free);
   assign req_ready  = ~s1_valid_ff | s1_adv;
   assign req_accept = req_valid & req_ready;

   // hold the request in the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_byte_ff <= req_text_byte;
         s1_last_ff <= req_line_end;
         s1_tag_ff  <= req_line_tag;
      end
   end

   // register the line result until it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv && s1_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_last_ff) begin
         rsp_tag_ff   <= s1_tag_ff;
         rsp_found_ff <= found;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_tag_out   = rsp_tag_ff;
   assign rsp_all_found = rsp_found_ff;

endmodule

/* rtl/awsm_csr.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// awsm_csr
// Configuration registers behind a zero-wait APB-style port: query words,
// word lengths, word count and the first-byte fold flag.
// -----------------------------------------------------------------------------
module awsm_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [awsm_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [awsm_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [awsm_pkg::DATA_W-1:0]   csr_prdata,
   output logic                          csr_pready,
   output awsm_pkg::cfg_type             cfg
);
   import awsm_pkg::*;

   cfg_type           cfg_ff;
   logic              wr_en;
   logic [IDX_W-1:0]  idx;

   assign idx        = csr_paddr[ADDR_W-1:ADDR_W-IDX_W];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // write the addressed register
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (wr_en) begin
         case (idx)
            REG_QUERY_0: cfg_ff.words[0] <= csr_pwdata[QWORD_W-1:0];
            REG_QUERY_1: cfg_ff.words[1] <= csr_pwdata[QWORD_W-1:0];
            REG_QUERY_2: cfg_ff.words[2] <= csr_pwdata[QWORD_W-1:0];
            REG_QUERY_3: cfg_ff.words[3] <= csr_pwdata[QWORD_W-1:0];
            REG_LENGTHS: cfg_ff.lengths  <= csr_pwdata[REG_WORDS*LEN_W-1:0];
            REG_COUNT:   cfg_ff.count    <= csr_pwdata[COUNT_W-1:0];
            REG_FOLD:    cfg_ff.fold     <= csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   // read back
   always_comb begin
      case (idx)
         REG_QUERY_0: csr_prdata = DATA_W'(cfg_ff.words[0]);
         REG_QUERY_1: csr_prdata = DATA_W'(cfg_ff.words[1]);
         REG_QUERY_2: csr_prdata = DATA_W'(cfg_ff.words[2]);
         REG_QUERY_3: csr_prdata = DATA_W'(cfg_ff.words[3]);
         REG_LENGTHS: csr_prdata = DATA_W'(cfg_ff.lengths);
         REG_COUNT:   csr_prdata = DATA_W'(cfg_ff.count);
         REG_FOLD:    csr_prdata = DATA_W'(cfg_ff.fold);
         default:     csr_prdata = '0;
      endcase
   end

endmodule

/* rtl/awsm_match.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// awsm_match
// Line state and comparators: a shift window of the latest bytes of the
// line, its fill count, one comparator set per query word and the found bits.
// -----------------------------------------------------------------------------
module awsm_match #(
   parameter int MAX_WORDS  = awsm_pkg::DEF_MAX_WORDS,
   parameter int WORD_BYTES = awsm_pkg::DEF_WORD_BYTES
) (
   input  logic              clock,
   input  logic              reset,
   input  awsm_pkg::cfg_type cfg,
   input  logic              advance,
   input  logic [7:0]        text_byte,
   input  logic              line_end,
   output logic              all_found
);
   import awsm_pkg::*;

   localparam int USED   = (MAX_WORDS < REG_WORDS) ? MAX_WORDS : REG_WORDS;
   localparam int CAP    = (WORD_BYTES < REG_BYTES) ? WORD_BYTES : REG_BYTES;
   localparam int FILL_W = $clog2(WORD_BYTES + 1);

   logic [7:0]        win_ff [WORD_BYTES];
   logic [7:0]        win_in [WORD_BYTES];
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [USED-1:0]   seen_ff, seen_in;
   logic              start_ff;
   logic [7:0]        byte_fold;
   logic [COUNT_W-1:0] n_eff;
   logic [USED-1:0]   use_mask;
   logic [USED-1:0]   hit;

   // fold the first byte of a line to lower case
   always_comb begin
      byte_fold = text_byte;
      if (start_ff && cfg.fold && text_byte >= CHAR_UPPER_A && text_byte <= CHAR_UPPER_Z)
         byte_fold = text_byte + CASE_OFFSET;
   end

   // shift the new byte into the window and count it
   always_comb begin
      win_in[0] = byte_fold;
      for (int i = 1; i < WORD_BYTES; i++)
         win_in[i] = win_ff[i-1];
      fill_in = (fill_ff == FILL_W'(WORD_BYTES)) ? fill_ff : fill_ff + FILL_W'(1);
   end

   // words in use
   always_comb begin
      n_eff = (cfg.count > COUNT_W'(USED)) ? COUNT_W'(USED) : cfg.count;
      for (int k = 0; k < USED; k++)
         use_mask[k] = (COUNT_W'(k) < n_eff);
   end

   // compare every word against the window at its own length
   always_comb begin
      logic [LEN_W-1:0] len_raw;
      logic [LEN_W-1:0] len_eff;
      logic             cand;
      len_raw = '0;
      len_eff = '0;
      cand    = 1'b0;
      for (int k = 0; k < USED; k++) begin
         len_raw = cfg.lengths[LEN_W*k +: LEN_W];
         len_eff = (len_raw > LEN_W'(CAP)) ? LEN_W'(CAP) : len_raw;
         hit[k]  = (len_eff == '0);
         for (int l = 1; l <= CAP; l++) begin
            cand = (fill_in >= FILL_W'(l));
            for (int i = 0; i < l; i++)
               cand = cand & (win_in[l-1-i] == cfg.words[k][8*i +: 8]);
            if (len_eff == LEN_W'(l))
               hit[k] = cand;
         end
      end
   end

   assign seen_in   = seen_ff | (hit & use_mask);
   assign all_found = &(seen_in | ~use_mask);

   // advance line state; drop it at the end of a line
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         seen_ff  <= '0;
         start_ff <= 1'b1;
      end else if (advance) begin
         if (line_end) begin
            fill_ff  <= '0;
            seen_ff  <= '0;
            start_ff <= 1'b1;
         end else begin
            fill_ff  <= fill_in;
            seen_ff  <= seen_in;
            start_ff <= 1'b0;
         end
      end
   end

   // window bytes are qualified by the fill count
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < WORD_BYTES; i++)
            win_ff[i] <= win_in[i];
      end
   end

endmodule

/* dv/all_words_substring_matcher_tb.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// all_words_substring_matcher_tb
// Self-checking bench for the all-words substring matcher. Text bytes are
// streamed through the request channel with random gaps, and line results are
// drained with random stalls. A scoreboard keeps its own copy of the query
// setup and the per-line scan state, and it checks every line verdict in
// order. Query setups are reloaded over the register port between phases.
// -----------------------------------------------------------------------------
module all_words_substring_matcher_tb;
   import awsm_pkg::*;

   // limits that the block applies to the query setup
   localparam int SCAN_WORDS = (REG_WORDS < DEF_MAX_WORDS) ? REG_WORDS : DEF_MAX_WORDS;
   localparam int SCAN_BYTES = (REG_BYTES < DEF_WORD_BYTES) ? REG_BYTES : DEF_WORD_BYTES;

   localparam logic [IDX_W-1:0] BAD_INDEX = 3'd7;
   localparam int RANDOM_BYTES  = 1430;
   localparam int SETTLE_CYCLES = 6;
   localparam int STALL_LIMIT   = 2000;

   typedef struct {
      logic [7:0] text;
      logic       last;
      logic [7:0] tag;
      bit         drain;
   } text_req_type;

   typedef struct packed {
      logic [7:0] tag;
      logic       found;
   } line_verdict_type;

   logic                clock;
   logic                reset         = 1'b1;
   logic                req_valid     = 1'b0;
   logic                req_ready;
   logic [7:0]          req_text_byte = '0;
   logic                req_line_end  = 1'b0;
   logic [7:0]          req_line_tag  = '0;
   logic                rsp_valid;
   logic                rsp_ready     = 1'b0;
   logic [7:0]          rsp_tag_out;
   logic                rsp_all_found;
   logic                csr_psel      = 1'b0;
   logic                csr_penable   = 1'b0;
   logic                csr_pwrite    = 1'b0;
   logic [ADDR_W-1:0]   csr_paddr     = '0;
   logic [DATA_W-1:0]   csr_pwdata    = '0;
   logic [DATA_W-1:0]   csr_prdata;
   logic                csr_pready;

   // query setup as seen by the block, tracked from register writes
   logic [QWORD_W-1:0]  mirror_words [REG_WORDS] = '{default: '0};
   logic [15:0]         mirror_lens   = '0;
   logic [COUNT_W-1:0]  mirror_count  = '0;
   logic                mirror_fold   = 1'b0;

   // per-line scan state
   logic [SCAN_BYTES*8-1:0] window_bytes = '0;
   int                      window_fill  = 0;
   logic [SCAN_WORDS-1:0]   words_found  = '0;
   logic                    line_fresh   = 1'b1;

   // setup that the stimulus is built around
   logic [QWORD_W-1:0]  plan_words [REG_WORDS];
   logic [15:0]         plan_lens;
   logic [COUNT_W-1:0]  plan_count;
   logic                plan_fold;

   text_req_type        text_backlog [$];
   line_verdict_type    line_verdicts [$];
   text_req_type        next_req;
   line_verdict_type    verdict;
   string               letters = "abcAZ ,.\n";

   bit                  send_pauses_on = 1'b1;
   bit                  rsp_pauses_on  = 1'b1;
   int                  send_gap       = 0;
   int                  accept_stall   = 0;
   bit                  req_taken      = 1'b0;
   bit                  moved;
   int                  idle_cycles    = 0;
   int                  bytes_scanned  = 0;
   int                  results_checked = 0;
   int                  setups_loaded  = 0;
   int                  random_bytes   = 0;
   int                  mismatches     = 0;

   all_words_substring_matcher dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_text_byte (req_text_byte),
      .req_line_end  (req_line_end),
      .req_line_tag  (req_line_tag),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_tag_out   (rsp_tag_out),
      .rsp_all_found (rsp_all_found),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly no pause, sometimes a short one, rarely a long one
   function automatic int draw_pause(bit enabled);
      int r;
      if (!enabled) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // pack a string into a query word, first byte lowest
   function automatic logic [QWORD_W-1:0] pack_word(string s);
      logic [QWORD_W-1:0] w;
      w = '0;
      for (int i = 0; i < s.len() && i < REG_BYTES; i++) w[8*i +: 8] = s[i];
      return w;
   endfunction

   // advance the line scan by one byte and queue the verdict on the last one
   task automatic scan_byte(input logic [7:0] raw, input logic last, input logic [7:0] tag);
      logic [7:0] b;
      int         in_use;
      int         len;
      bit         hit;
      bit         all;
      b = raw;
      if (line_fresh && mirror_fold && b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z)
         b = b + CASE_OFFSET;
      line_fresh = 1'b0;
      window_bytes = {window_bytes[SCAN_BYTES*8-9:0], b};
      if (window_fill < SCAN_BYTES) window_fill++;
      in_use = (int'(mirror_count) > SCAN_WORDS) ? SCAN_WORDS : int'(mirror_count);
      for (int k = 0; k < in_use; k++) begin
         len = mirror_lens[4*k +: 4];
         if (len > SCAN_BYTES) len = SCAN_BYTES;
         hit = (window_fill >= len);
         for (int i = 0; i < len; i++) begin
            if (window_bytes[8*(len-1-i) +: 8] != mirror_words[k][8*i +: 8]) hit = 1'b0;
         end
         if (hit) words_found[k] = 1'b1;
      end
      if (last) begin
         all = 1'b1;
         for (int k = 0; k < in_use; k++) begin
            if (!words_found[k]) all = 1'b0;
         end
         line_verdicts.push_back('{tag: tag, found: all});
         window_bytes = '0;
         window_fill  = 0;
         words_found  = '0;
         line_fresh   = 1'b1;
      end
   endtask

   task automatic push_byte(input logic [7:0] b, input logic last, input logic [7:0] tag,
                            input bit drain);
      text_backlog.push_back('{text: b, last: last, tag: tag, drain: drain});
   endtask

   task automatic push_text(input string s, input bit ends, input logic [7:0] tag);
      for (int i = 0; i < s.len(); i++) push_byte(s[i], ends && (i == s.len() - 1), tag, 1'b0);
   endtask

   // setup cycle, then access cycle; the register takes the data at the access edge
   task automatic csr_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic load_setup();
      csr_write(REG_QUERY_0, plan_words[0]);
      csr_write(REG_QUERY_1, plan_words[1]);
      csr_write(REG_QUERY_2, plan_words[2]);
      csr_write(REG_QUERY_3, plan_words[3]);
      csr_write(REG_LENGTHS, DATA_W'(plan_lens));
      csr_write(REG_COUNT, DATA_W'(plan_count));
      csr_write(REG_FOLD, DATA_W'(plan_fold));
      setups_loaded++;
   endtask

   // drain everything in flight, then give the block time to settle
   task automatic wait_idle();
      while (text_backlog.size() != 0 || req_valid || line_verdicts.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // request driver: hold until taken, then pause or present the next byte
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         req_valid <= 1'b1;
      end else if (send_gap > 0) begin
         req_valid <= 1'b0;
         send_gap--;
      end else if (text_backlog.size() != 0 &&
                   !(text_backlog[0].drain && line_verdicts.size() != 0)) begin
         next_req = text_backlog.pop_front();
         req_text_byte <= next_req.text;
         req_line_end  <= next_req.last;
         req_line_tag  <= next_req.tag;
         req_valid     <= 1'b1;
         send_gap = draw_pause(send_pauses_on);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // result acceptor with random stalls
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (accept_stall > 0) begin
         rsp_ready <= 1'b0;
         accept_stall--;
      end else begin
         rsp_ready <= 1'b1;
         accept_stall = draw_pause(rsp_pauses_on);
      end
   end

   // monitor: track register writes, predict on requests, check results
   always @(posedge clock) begin
      req_taken = 1'b0;
      moved     = 1'b0;
      if (!reset) begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            moved = 1'b1;
            case (csr_paddr[ADDR_W-1:3])
               REG_QUERY_0: mirror_words[0] = csr_pwdata;
               REG_QUERY_1: mirror_words[1] = csr_pwdata;
               REG_QUERY_2: mirror_words[2] = csr_pwdata;
               REG_QUERY_3: mirror_words[3] = csr_pwdata;
               REG_LENGTHS: mirror_lens  = csr_pwdata[15:0];
               REG_COUNT:   mirror_count = csr_pwdata[COUNT_W-1:0];
               REG_FOLD:    mirror_fold  = csr_pwdata[0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            moved = 1'b1;
            if (line_verdicts.size() == 0) begin
               $error("unexpected result: tag_out %0d all_found %0b", rsp_tag_out,
                      rsp_all_found);
               mismatches++;
            end else begin
               verdict = line_verdicts.pop_front();
               results_checked++;
               if (rsp_tag_out !== verdict.tag) begin
                  $error("tag_out mismatch: expected %0d, got %0d", verdict.tag, rsp_tag_out);
                  mismatches++;
               end
               if (rsp_all_found !== verdict.found) begin
                  $error("all_found mismatch: expected %0b, got %0b", verdict.found,
                         rsp_all_found);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            moved     = 1'b1;
            req_taken = 1'b1;
            bytes_scanned++;
            scan_byte(req_text_byte, req_line_end, req_line_tag);
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
      end
   end

   // watchdog: end the run if nothing moves for too long
   initial begin
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("FAIL");
      $finish;
   end

   initial begin
      logic [7:0] line_bytes [$];
      int         line_len;
      int         phase_lines;
      int         k;
      int         wl;
      int         r;
      bit         ends;
      bit         drain;
      logic [7:0] tag;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // no words in use after reset: every line matches, extreme bytes and tags
      push_byte(8'h00, 1'b1, 8'h00, 1'b0);
      push_byte(8'hFF, 1'b1, 8'hFF, 1'b0);
      wait_idle();

      // folded first byte, empty word, over-long length, zero byte, count above four
      plan_words[0] = pack_word("ab");
      plan_words[1] = '0;
      plan_words[2] = pack_word("qrstuvwx");
      plan_words[3] = '0;
      plan_lens     = 16'h1F02;
      plan_count    = 3'd7;
      plan_fold     = 1'b1;
      load_setup();
      push_text("Ab", 1'b0, 8'd1);
      push_byte(8'h00, 1'b1, 8'd1, 1'b0);
      // hold this line back until the previous verdict is out
      push_byte("A", 1'b0, 8'd2, 1'b1);
      push_text("b", 1'b0, 8'd2);
      push_byte(8'h00, 1'b0, 8'd2, 1'b0);
      push_text("qrstuvwx", 1'b1, 8'd2);
      wait_idle();

      // word found before a mid-line rewrite stays found
      plan_words[0] = pack_word("a");
      plan_lens     = 16'h0001;
      plan_count    = 3'd1;
      plan_fold     = 1'b0;
      load_setup();
      push_text("a", 1'b0, 8'd0);
      wait_idle();
      plan_words[0] = pack_word("z");
      csr_write(REG_QUERY_0, plan_words[0]);
      push_text("b", 1'b1, 8'd3);
      wait_idle();

      // ignored register index; short lines; earlier lines never count
      csr_write(BAD_INDEX, '1);
      plan_words[0] = pack_word("zz");
      plan_lens     = 16'h0002;
      load_setup();
      push_text("z", 1'b1, 8'd4);
      push_text("z", 1'b1, 8'd5);
      push_text("zz", 1'b1, 8'd6);
      wait_idle();

      // random phases: fresh setup, then lines built around its words
      while (random_bytes < RANDOM_BYTES) begin
         send_pauses_on = ($urandom_range(0, 3) != 0);
         rsp_pauses_on  = ($urandom_range(0, 3) != 0);
         for (int w = 0; w < REG_WORDS; w++) begin
            r = $urandom_range(0, 9);
            if (r == 0) plan_words[w] = '1;
            else if (r == 1) plan_words[w] = '0;
            else if (r == 2) plan_words[w] = {$urandom, $urandom};
            else begin
               for (int i = 0; i < REG_BYTES; i++)
                  plan_words[w][8*i +: 8] = letters[$urandom_range(0, letters.len() - 1)];
            end
            r = $urandom_range(0, 9);
            if (r < 6) plan_lens[4*w +: 4] = 4'($urandom_range(1, 4));
            else if (r == 6) plan_lens[4*w +: 4] = 4'($urandom_range(5, 8));
            else if (r == 7) plan_lens[4*w +: 4] = 4'd0;
            else if (r == 8) plan_lens[4*w +: 4] = 4'($urandom_range(9, 15));
            else plan_lens[4*w +: 4] = 4'd8;
         end
         r = $urandom_range(0, 9);
         if (r == 0) plan_count = 3'd0;
         else if (r == 1) plan_count = 3'($urandom_range(5, 7));
         else plan_count = 3'($urandom_range(1, 4));
         plan_fold = 1'($urandom_range(0, 1));
         load_setup();
         if ($urandom_range(0, 4) == 0) csr_write(BAD_INDEX, {$urandom, $urandom});

         phase_lines = $urandom_range(4, 16);
         for (int j = 0; j < phase_lines; j++) begin
            // the last line of a phase is sometimes left open across the reload
            ends = (j < phase_lines - 1) || ($urandom_range(0, 3) != 0);
            line_len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48)
                                                   : $urandom_range(1, 14);
            line_bytes.delete();
            while (line_bytes.size() < line_len) begin
               r = $urandom_range(0, 9);
               if (r < 3) begin
                  k  = $urandom_range(0, REG_WORDS - 1);
                  wl = plan_lens[4*k +: 4];
                  if (wl > SCAN_BYTES) wl = SCAN_BYTES;
                  for (int i = 0; i < wl; i++) line_bytes.push_back(plan_words[k][8*i +: 8]);
                  if (wl == 0) line_bytes.push_back(letters[$urandom_range(0, letters.len() - 1)]);
               end else if (r == 3) begin
                  line_bytes.push_back(8'($urandom_range(0, 255)));
               end else begin
                  line_bytes.push_back(letters[$urandom_range(0, letters.len() - 1)]);
               end
            end
            // uppercase the opening letter now and then to exercise folding
            if (line_bytes[0] >= "a" && line_bytes[0] <= "z" && $urandom_range(0, 1) == 1)
               line_bytes[0] = line_bytes[0] - CASE_OFFSET;
            tag   = 8'($urandom_range(0, 255));
            drain = ($urandom_range(0, 29) == 0);
            for (int i = 0; i < line_bytes.size(); i++) begin
               if (i == line_bytes.size() - 1)
                  push_byte(line_bytes[i], ends, tag, drain && i == 0);
               else
                  push_byte(line_bytes[i], 1'b0, 8'($urandom_range(0, 255)), drain && i == 0);
            end
            random_bytes += line_bytes.size();
         end
         wait_idle();
      end

      $display("Scanned %0d text bytes under %0d query setups; checked %0d line verdicts.",
               bytes_scanned, setups_loaded, results_checked);
      $display("Mismatches seen: %0d.", mismatches);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

/* all_words_substring_matcher.f */
rtl/awsm_pkg.sv
rtl/awsm_csr.sv
rtl/awsm_match.sv
rtl/all_words_substring_matcher.sv
dv/all_words_substring_matcher_tb.sv
